@@ hw/rtl/lgs_pkg.sv @@
// Shared types, field widths and codes for the life grid generation step block.
`default_nettype none

package lgs_pkg;

   // Field widths of the request and response channels
   localparam int CMD_W   = 2;
   localparam int COORD_W = 6;
   localparam int COUNT_W = 4;

   // Default grid size
   localparam int GRID_COLS_DEF = 64;
   localparam int GRID_ROWS_DEF = 64;

   // B3/S23 neighbour counts
   localparam logic [COUNT_W-1:0] BIRTH_COUNT   = COUNT_W'(3);
   localparam logic [COUNT_W-1:0] SURVIVE_COUNT = COUNT_W'(2);

   // Request commands
   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_STEP  = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_FETCH_PREV,
      ST_FETCH_MID,
      ST_FETCH_NEXT,
      ST_RUN,
      ST_WR_FETCH,
      ST_WR_COMMIT,
      ST_RESULT
   } lgs_state_type;

   // Read pointer operations
   typedef enum logic [1:0] {
      RP_HOLD,
      RP_PREV,
      RP_BASE,
      RP_INC
   } lgs_rp_op_type;

   // Write data sources
   typedef enum logic {
      WSRC_PATCH,
      WSRC_NEXT
   } lgs_wsrc_type;

   // Controller to datapath commands
   typedef struct packed {
      logic          capture;
      lgs_rp_op_type rp_op;
      logic          rd_en;
      logic          shift;
      logic          save_first;
      logic          scan_clr;
      logic          scan_inc;
      logic          wr_en;
      lgs_wsrc_type  wr_src;
      logic          rsp_load;
   } lgs_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic             in_range;
      logic             scan_last;
   } lgs_status_type;

endpackage

`default_nettype wire

@@ hw/rtl/lgs_req_if.sv @@
// Request channel interface: command, cell coordinates and write state.
`default_nettype none

interface lgs_req_if
   import lgs_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   command;
   logic [COORD_W-1:0] col;
   logic [COORD_W-1:0] row;
   logic               alive_in;

   modport source (output valid, command, col, row, alive_in, input ready);
   modport sink   (input valid, command, col, row, alive_in, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/lgs_rsp_if.sv @@
// Response channel interface: cell state and live neighbour count.
`default_nettype none

interface lgs_rsp_if
   import lgs_pkg::*;
();
   logic               valid;
   logic               ready;
   logic               cell_alive;
   logic [COUNT_W-1:0] neighbour_count;

   modport source (output valid, cell_alive, neighbour_count, input ready);
   modport sink   (input valid, cell_alive, neighbour_count, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/life_grid_generation_step.sv @@
// Top level: toroidal B3/S23 grid with cell write, cell read and generation step.
//
//   channel   role    handshake          payload
//   req_link  sink    valid / ready      command, col, row, alive_in
//   rsp_link  source  valid / ready      cell_alive, neighbour_count
//
// One request is worked at a time; the next is taken while a response still waits.
// Cell write: fetch column, patch, store, then load the response.
// Cell read: three column fetches through the single memory read port.
// Generation step: one column per cycle through a three-column window.
// Reset clears the column valid bits, so the grid reads all dead; no clearing pass.
// A stalled response holds the block in its result state until the transfer.
`default_nettype none

module life_grid_generation_step
   import lgs_pkg::*;
#(
   parameter int GRID_COLS = GRID_COLS_DEF,
   parameter int GRID_ROWS = GRID_ROWS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   lgs_req_if.sink   req_link,
   lgs_rsp_if.source rsp_link
);

   lgs_cmd_type    cmd;
   lgs_status_type status;

   lgs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_link.valid),
      .req_ready (req_link.ready),
      .rsp_ready (rsp_link.ready),
      .rsp_valid (rsp_link.valid),
      .status    (status),
      .cmd       (cmd)
   );

   lgs_datapath #(
      .GRID_COLS (GRID_COLS),
      .GRID_ROWS (GRID_ROWS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_command         (req_link.command),
      .req_col             (req_link.col),
      .req_row             (req_link.row),
      .req_alive_in        (req_link.alive_in),
      .rsp_cell_alive      (rsp_link.cell_alive),
      .rsp_neighbour_count (rsp_link.neighbour_count)
   );

endmodule

`default_nettype wire

@@ hw/rtl/lgs_datapath.sv @@
// Datapath: grid memory, three-line column window, rule logic and response register.
`default_nettype none

module lgs_datapath
   import lgs_pkg::*;
#(
   parameter int GRID_COLS = GRID_COLS_DEF,
   parameter int GRID_ROWS = GRID_ROWS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire lgs_cmd_type        cmd,
   output lgs_status_type          status,
   input  wire logic [CMD_W-1:0]   req_command,
   input  wire logic [COORD_W-1:0] req_col,
   input  wire logic [COORD_W-1:0] req_row,
   input  wire logic               req_alive_in,
   output logic                    rsp_cell_alive,
   output logic [COUNT_W-1:0]      rsp_neighbour_count
);

   localparam int CW = $clog2(GRID_COLS);
   localparam int RW = $clog2(GRID_ROWS);
   localparam logic [CW-1:0] LAST_COL = CW'(GRID_COLS - 1);
   localparam logic [RW-1:0] LAST_ROW = RW'(GRID_ROWS - 1);

   typedef logic [GRID_ROWS-1:0] word_type;

   // Eight wrapped neighbours of row r in a three-column window
   function automatic logic [7:0] ring_bits(word_type lo, word_type mid, word_type hi,
                                            logic [RW-1:0] r);
      logic [RW-1:0] up;
      logic [RW-1:0] dn;
      up = (r == '0) ? LAST_ROW : r - RW'(1);
      dn = (r == LAST_ROW) ? '0 : r + RW'(1);
      return {lo[up], lo[r], lo[dn], mid[up], mid[dn], hi[up], hi[r], hi[dn]};
   endfunction

   // Captured request
   logic [CMD_W-1:0]   cmd_ff;
   logic [COORD_W-1:0] col_ff;
   logic [COORD_W-1:0] row_ff;
   logic               alive_ff;

   // Control and window registers
   logic [CW-1:0]        rp_ff, rp_in;
   logic [CW-1:0]        scan_ff, scan_in;
   logic [GRID_COLS-1:0] valid_ff, valid_in;
   logic                 rd_valid_ff;
   word_type             mem_rd_ff;
   word_type             win_lo_ff, win_mid_ff, first_ff;
   logic                 rsp_alive_ff, rsp_alive_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;

   // Grid storage, one word per column
   word_type grid_mem [GRID_COLS];

   logic [CW-1:0]      col_idx;
   logic [RW-1:0]      row_idx;
   logic [CW-1:0]      base_col;
   logic               in_range;
   logic               scan_last;
   word_type           rd_word;
   word_type           right_word;
   word_type           next_word;
   word_type           patch_word;
   word_type           wr_data;
   logic [CW-1:0]      wr_addr;
   logic [COUNT_W-1:0] read_count;

   assign col_idx   = col_ff[CW-1:0];
   assign row_idx   = row_ff[RW-1:0];
   assign in_range  = ({1'b0, col_ff} < (COORD_W + 1)'(GRID_COLS))
                   && ({1'b0, row_ff} < (COORD_W + 1)'(GRID_ROWS));
   assign base_col  = (cmd_ff == CMD_STEP) ? '0 : col_idx;
   assign scan_last = (scan_ff == LAST_COL);

   assign status.command   = cmd_ff;
   assign status.in_range  = in_range;
   assign status.scan_last = scan_last;

   // Columns never written since reset read as dead
   assign rd_word = rd_valid_ff ? mem_rd_ff : '0;

   // Last column of a generation wraps onto the saved old first column
   assign right_word = ((cmd_ff == CMD_STEP) && scan_last) ? first_ff : rd_word;

   // Apply B3/S23 to every row of the center column
   always_comb begin
      logic [COUNT_W-1:0] cnt_v;
      next_word = '0;
      for (int r = 0; r < GRID_ROWS; r++) begin
         cnt_v = COUNT_W'($countones(ring_bits(win_lo_ff, win_mid_ff, right_word, RW'(r))));
         next_word[r] = (cnt_v == BIRTH_COUNT)
                     || (win_mid_ff[r] && (cnt_v == SURVIVE_COUNT));
      end
   end

   // Replace one cell of the fetched column
   always_comb begin
      patch_word          = rd_word;
      patch_word[row_idx] = alive_ff;
   end

   assign read_count = COUNT_W'($countones(ring_bits(win_lo_ff, win_mid_ff, right_word, row_idx)));

   // Select write port
   always_comb begin
      unique case (cmd.wr_src)
         WSRC_PATCH: begin
            wr_addr = col_idx;
            wr_data = patch_word;
         end
         WSRC_NEXT: begin
            wr_addr = scan_ff;
            wr_data = next_word;
         end
         default: begin
            wr_addr = col_idx;
            wr_data = patch_word;
         end
      endcase
   end

   // Next values of pointer, scan, valid bits and response
   always_comb begin
      unique case (cmd.rp_op)
         RP_HOLD: rp_in = rp_ff;
         RP_PREV: rp_in = (base_col == '0) ? LAST_COL : base_col - CW'(1);
         RP_BASE: rp_in = base_col;
         RP_INC:  rp_in = (rp_ff == LAST_COL) ? '0 : rp_ff + CW'(1);
         default: rp_in = rp_ff;
      endcase

      scan_in = scan_ff;
      if (cmd.scan_clr) begin
         scan_in = '0;
      end else if (cmd.scan_inc) begin
         scan_in = scan_last ? '0 : scan_ff + CW'(1);
      end

      valid_in = valid_ff;
      if (cmd.wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end

      rsp_alive_in = rsp_alive_ff;
      rsp_count_in = rsp_count_ff;
      if (cmd.rsp_load) begin
         if ((cmd_ff == CMD_READ) && in_range) begin
            rsp_alive_in = win_mid_ff[row_idx];
            rsp_count_in = read_count;
         end else begin
            rsp_alive_in = 1'b0;
            rsp_count_in = '0;
         end
      end
   end

   // Control state with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         rp_ff       <= '0;
         scan_ff     <= '0;
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         rp_ff    <= rp_in;
         scan_ff  <= scan_in;
         valid_ff <= valid_in;
         if (cmd.rd_en) begin
            rd_valid_ff <= valid_ff[rp_ff];
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff   <= req_command;
         col_ff   <= req_col;
         row_ff   <= req_row;
         alive_ff <= req_alive_in;
      end
      if (cmd.shift) begin
         win_lo_ff  <= win_mid_ff;
         win_mid_ff <= rd_word;
      end
      if (cmd.save_first) begin
         first_ff <= rd_word;
      end
      rsp_alive_ff <= rsp_alive_in;
      rsp_count_ff <= rsp_count_in;
   end

   // Grid memory read port
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         mem_rd_ff <= grid_mem[rp_ff];
      end
   end

   // Grid memory write port
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         grid_mem[wr_addr] <= wr_data;
      end
   end

   assign rsp_cell_alive      = rsp_alive_ff;
   assign rsp_neighbour_count = rsp_count_ff;

   // A generation writes exactly the column under the scan
   a_step_write_addr: assert property (@(posedge clock) disable iff (reset)
      (cmd.wr_en && (cmd.wr_src == WSRC_NEXT)) |-> (wr_addr == scan_ff))
      else $error("generation write off the scan column");

   // A response never carries a count above eight
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |=> (rsp_count_ff <= COUNT_W'(8)))
      else $error("neighbour count out of range");

   // Non-read responses are zero
   a_zero_rsp: assert property (@(posedge clock) disable iff (reset)
      (cmd.rsp_load && (cmd_ff != CMD_READ)) |=> (!rsp_alive_ff && (rsp_count_ff == '0)))
      else $error("non-read response not zero");

endmodule

`default_nettype wire

@@ hw/rtl/lgs_ctrl.sv @@
// Controller: sequences writes, reads and generation scans over the datapath.
`default_nettype none

module lgs_ctrl
   import lgs_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   input  wire logic           rsp_ready,
   output logic                rsp_valid,
   input  wire lgs_status_type status,
   output lgs_cmd_type         cmd
);

   lgs_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            priority if ((status.command == CMD_WRITE) && status.in_range) begin
               state_in = ST_WR_FETCH;
            end else if ((status.command == CMD_READ) && status.in_range) begin
               state_in = ST_FETCH_PREV;
            end else if (status.command == CMD_STEP) begin
               state_in = ST_FETCH_PREV;
            end else begin
               state_in = ST_RESULT;
            end
         end
         ST_FETCH_PREV: state_in = ST_FETCH_MID;
         ST_FETCH_MID:  state_in = ST_FETCH_NEXT;
         ST_FETCH_NEXT: state_in = (status.command == CMD_STEP) ? ST_RUN : ST_RESULT;
         ST_RUN: begin
            if (status.scan_last) begin
               state_in = ST_RESULT;
            end
         end
         ST_WR_FETCH:  state_in = ST_WR_COMMIT;
         ST_WR_COMMIT: state_in = ST_RESULT;
         ST_RESULT: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath commands
   always_comb begin
      cmd            = '0;
      cmd.rp_op      = RP_HOLD;
      cmd.wr_src     = WSRC_PATCH;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.capture = req_valid;
         end
         ST_DECODE: begin
            cmd.rp_op    = (status.command == CMD_WRITE) ? RP_BASE : RP_PREV;
            cmd.scan_clr = 1'b1;
         end
         ST_FETCH_PREV: begin
            cmd.rd_en = 1'b1;
            cmd.rp_op = RP_INC;
         end
         ST_FETCH_MID: begin
            cmd.rd_en = 1'b1;
            cmd.rp_op = RP_INC;
            cmd.shift = 1'b1;
         end
         ST_FETCH_NEXT: begin
            cmd.rd_en      = 1'b1;
            cmd.rp_op      = RP_INC;
            cmd.shift      = 1'b1;
            cmd.save_first = 1'b1;
         end
         ST_RUN: begin
            cmd.rd_en    = 1'b1;
            cmd.rp_op    = RP_INC;
            cmd.shift    = 1'b1;
            cmd.scan_inc = 1'b1;
            cmd.wr_en    = 1'b1;
            cmd.wr_src   = WSRC_NEXT;
         end
         ST_WR_FETCH: begin
            cmd.rd_en = 1'b1;
         end
         ST_WR_COMMIT: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_src = WSRC_PATCH;
         end
         ST_RESULT: begin
            cmd.rsp_load = rsp_free;
         end
         default: begin
            cmd.capture = 1'b0;
         end
      endcase
   end

   // Response valid: set on load, drop on transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // A waiting response is never overwritten
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> rsp_free)
      else $error("response overwritten before transfer");

   // An accepted request is decoded in the next cycle
   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_DECODE))
      else $error("accepted request not decoded");

   // The scan ends on the last column
   a_scan_end: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_RUN) && status.scan_last) |=> (state_ff == ST_RESULT))
      else $error("generation scan did not end on last column");

   // A loaded response shows valid next cycle
   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |=> rsp_valid_ff)
      else $error("loaded response not valid");

endmodule

`default_nettype wire

@@ sim/tb_life_grid_generation_step.sv @@
// Self-checking testbench for the toroidal B3/S23 life grid: cell write, cell read, step.
`default_nettype none

module tb_life_grid_generation_step
   import lgs_pkg::*;
();

   localparam int GRID_COLS       = GRID_COLS_DEF;
   localparam int GRID_ROWS       = GRID_ROWS_DEF;
   localparam int REQUEST_TARGET  = 1700;
   localparam int RUN_CYCLE_LIMIT = 1_000_000;
   localparam int SETTLE_CYCLES   = 100;
   localparam int PHASE_LEN       = 200;
   localparam int HOLD_CYCLES     = 400;
   localparam int FIRST_HOLD_AT   = 500;
   localparam int SECOND_HOLD_AT  = 1300;

   // Command code that the block does not define; it must change nothing
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef struct {
      logic [CMD_W-1:0]   command;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic               alive_in;
      bit                 drain;
   } grid_request_type;

   typedef struct packed {
      logic               cell_alive;
      logic [COUNT_W-1:0] neighbour_count;
   } cell_report_type;

   logic clock;
   logic reset;

   lgs_req_if req_link ();
   lgs_rsp_if rsp_link ();

   life_grid_generation_step #(
      .GRID_COLS (GRID_COLS),
      .GRID_ROWS (GRID_ROWS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_link (req_link),
      .rsp_link (rsp_link)
   );

   // Grid model: bit r of word c is the cell at column c, row r
   logic [GRID_ROWS-1:0] life_cols [GRID_COLS];

   grid_request_type pending_requests [$];
   cell_report_type  cell_reports_due [$];
   cell_report_type  arrived_report;

   int          request_total  = 0;
   int          accepted_count = 0;
   int          mismatch_count = 0;
   int unsigned cycle_count    = 0;
   int          hold_left;
   int          next_hold_at;
   int          idle_phase;
   int          tx_idle_pct;
   int          rx_stall_pct;

   // Cycle through: no idling, sender idle, receiver stall, both
   assign idle_phase   = (accepted_count / PHASE_LEN) % 4;
   assign tx_idle_pct  = (idle_phase == 1) ? 67 : (idle_phase == 3) ? 21 : 0;
   assign rx_stall_pct = (idle_phase == 2) ? 67 : (idle_phase == 3) ? 21 : 0;

   function automatic logic model_cell(int c, int r);
      return life_cols[c][r];
   endfunction

   function automatic logic [COUNT_W-1:0] model_live_count(int c, int r);
      int cl, cr, ru, rd;
      cl = (c == 0) ? GRID_COLS - 1 : c - 1;
      cr = (c == GRID_COLS - 1) ? 0 : c + 1;
      ru = (r == 0) ? GRID_ROWS - 1 : r - 1;
      rd = (r == GRID_ROWS - 1) ? 0 : r + 1;
      return COUNT_W'(model_cell(cl, ru)) + COUNT_W'(model_cell(cl, r))
           + COUNT_W'(model_cell(cl, rd)) + COUNT_W'(model_cell(c, ru))
           + COUNT_W'(model_cell(c, rd)) + COUNT_W'(model_cell(cr, ru))
           + COUNT_W'(model_cell(cr, r)) + COUNT_W'(model_cell(cr, rd));
   endfunction

   // Compute every new state from the old grid, then commit all at once
   function automatic void model_advance_generation();
      logic [GRID_ROWS-1:0] staged [GRID_COLS];
      logic [COUNT_W-1:0]   n;
      for (int c = 0; c < GRID_COLS; c++) begin
         for (int r = 0; r < GRID_ROWS; r++) begin
            n = model_live_count(c, r);
            if (model_cell(c, r)) begin
               staged[c][r] = (n == SURVIVE_COUNT) || (n == BIRTH_COUNT);
            end else begin
               staged[c][r] = (n == BIRTH_COUNT);
            end
         end
      end
      for (int c = 0; c < GRID_COLS; c++) begin
         life_cols[c] = staged[c];
      end
   endfunction

   // Apply one accepted request to the grid model and queue the report it yields
   function automatic void apply_to_grid_model(logic [CMD_W-1:0] command,
                                               logic [COORD_W-1:0] col,
                                               logic [COORD_W-1:0] row,
                                               logic alive_in);
      cell_report_type report;
      report = '0;
      case (command)
         CMD_WRITE: begin
            if (int'(col) < GRID_COLS && int'(row) < GRID_ROWS) begin
               life_cols[col][row] = alive_in;
            end
         end
         CMD_READ: begin
            if (int'(col) < GRID_COLS && int'(row) < GRID_ROWS) begin
               report.cell_alive      = model_cell(int'(col), int'(row));
               report.neighbour_count = model_live_count(int'(col), int'(row));
            end
         end
         CMD_STEP: begin
            model_advance_generation();
         end
         default: begin
         end
      endcase
      cell_reports_due.push_back(report);
   endfunction

   task automatic report_mismatch(string what);
      $display("ERROR at cycle %0d: %s", cycle_count, what);
      mismatch_count++;
   endtask

   task automatic queue_request(logic [CMD_W-1:0] command, int col, int row, logic alive_in);
      grid_request_type req;
      req.command  = command;
      req.col      = COORD_W'(col);
      req.row      = COORD_W'(row);
      req.alive_in = alive_in;
      req.drain    = 1'b0;
      pending_requests.push_back(req);
      request_total++;
   endtask

   task automatic queue_drain();
      grid_request_type req;
      req       = '{default: '0};
      req.drain = 1'b1;
      pending_requests.push_back(req);
   endtask

   task automatic queue_read_anywhere();
      queue_request(CMD_READ, $urandom_range(0, GRID_COLS - 1),
                    $urandom_range(0, GRID_ROWS - 1), 1'($urandom_range(0, 1)));
   endtask

   task automatic queue_step();
      queue_request(CMD_STEP, $urandom_range(0, GRID_COLS - 1),
                    $urandom_range(0, GRID_ROWS - 1), 1'($urandom_range(0, 1)));
   endtask

   // Seed a small wrapped patch, then read around it across a few generations
   task automatic queue_patch_run();
      int c0, r0, w, h, pct, gens;
      c0 = $urandom_range(0, GRID_COLS - 1);
      r0 = $urandom_range(0, GRID_ROWS - 1);
      w  = $urandom_range(3, 8);
      h  = $urandom_range(3, 8);
      case ($urandom_range(0, 2))
         0:       pct = 30;
         1:       pct = 55;
         default: pct = 90;
      endcase
      for (int i = 0; i < w; i++) begin
         for (int j = 0; j < h; j++) begin
            queue_request(CMD_WRITE, (c0 + i) % GRID_COLS, (r0 + j) % GRID_ROWS,
                          $urandom_range(0, 99) < pct);
         end
      end
      gens = $urandom_range(1, 3);
      for (int g = 0; g <= gens; g++) begin
         for (int k = 0; k < 4; k++) begin
            queue_request(CMD_READ,
                          (c0 + GRID_COLS - 1 + $urandom_range(0, w + 1)) % GRID_COLS,
                          (r0 + GRID_ROWS - 1 + $urandom_range(0, h + 1)) % GRID_ROWS,
                          1'($urandom_range(0, 1)));
         end
         if (g < gens) begin
            queue_step();
         end
      end
   endtask

   // Clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Stimulus, reset and end of run
   initial begin
      reset                  = 1'b1;
      req_link.valid         = 1'b0;
      req_link.command       = CMD_WRITE;
      req_link.col           = '0;
      req_link.row           = '0;
      req_link.alive_in      = 1'b0;
      rsp_link.ready         = 1'b0;
      for (int c = 0; c < GRID_COLS; c++) begin
         life_cols[c] = '0;
      end

      // Directed: empty grid, wrapped corners, unknown command, wrapped blinker
      queue_request(CMD_READ, 0, 0, 1'b1);
      queue_request(CMD_WRITE, 0, 0, 1'b1);
      queue_request(CMD_WRITE, GRID_COLS - 1, GRID_ROWS - 1, 1'b1);
      queue_request(CMD_WRITE, GRID_COLS - 1, 0, 1'b1);
      queue_request(CMD_WRITE, 0, GRID_ROWS - 1, 1'b1);
      queue_request(CMD_READ, 0, 0, 1'b0);
      queue_request(CMD_READ, GRID_COLS - 1, GRID_ROWS - 1, 1'b1);
      queue_request(CMD_UNUSED, GRID_COLS - 1, GRID_ROWS - 1, 1'b1);
      queue_request(CMD_WRITE, 1, 1, 1'b1);
      queue_request(CMD_READ, 0, 0, 1'b0);
      queue_request(CMD_STEP, 0, 0, 1'b0);
      queue_request(CMD_READ, 0, 0, 1'b0);
      queue_request(CMD_READ, 1, 1, 1'b0);
      queue_request(CMD_READ, GRID_COLS - 1, GRID_ROWS - 1, 1'b0);
      queue_request(CMD_WRITE, 0, 0, 1'b0);
      queue_request(CMD_READ, 0, 0, 1'b1);
      queue_request(CMD_WRITE, GRID_COLS - 1, 10, 1'b1);
      queue_request(CMD_WRITE, 0, 10, 1'b1);
      queue_request(CMD_WRITE, 1, 10, 1'b1);
      queue_request(CMD_STEP, GRID_COLS - 1, GRID_ROWS - 1, 1'b1);
      queue_request(CMD_READ, 0, 9, 1'b0);
      queue_request(CMD_READ, 0, 11, 1'b0);
      queue_request(CMD_READ, GRID_COLS - 1, 10, 1'b0);
      queue_request(CMD_STEP, 0, 0, 1'b0);
      queue_request(CMD_READ, GRID_COLS - 1, 10, 1'b1);
      queue_drain();

      // Random: mostly seeded patches, some noise, lone reads and steps
      while (request_total < REQUEST_TARGET) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: begin
               queue_patch_run();
               if ($urandom_range(0, 7) == 0) begin
                  queue_drain();
               end
            end
            7: begin
               for (int k = 0; k < 10; k++) begin
                  queue_request(CMD_W'($urandom_range(0, 3)), $urandom_range(0, GRID_COLS - 1),
                                $urandom_range(0, GRID_ROWS - 1), 1'($urandom_range(0, 1)));
               end
            end
            8: begin
               for (int k = 0; k < 5; k++) begin
                  queue_read_anywhere();
               end
            end
            default: begin
               queue_step();
            end
         endcase
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Wait for every request to transfer and every report to arrive
      while (pending_requests.size() != 0 || req_link.valid || cell_reports_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Request driver: predict on transfer, then offer the next request or idle
   always @(posedge clock) begin
      if (reset) begin
         req_link.valid <= 1'b0;
      end else begin
         if (req_link.valid && req_link.ready) begin
            apply_to_grid_model(req_link.command, req_link.col, req_link.row,
                                req_link.alive_in);
            accepted_count <= accepted_count + 1;
         end
         if (!req_link.valid || req_link.ready) begin
            if (pending_requests.size() != 0 && !pending_requests[0].drain &&
                $urandom_range(0, 99) >= tx_idle_pct) begin
               req_link.valid    <= 1'b1;
               req_link.command  <= pending_requests[0].command;
               req_link.col      <= pending_requests[0].col;
               req_link.row      <= pending_requests[0].row;
               req_link.alive_in <= pending_requests[0].alive_in;
               void'(pending_requests.pop_front());
            end else if (pending_requests.size() != 0 && pending_requests[0].drain &&
                         cell_reports_due.size() == 0) begin
               // Pause point reached: all reports are in, go on
               req_link.valid <= 1'b0;
               void'(pending_requests.pop_front());
            end else begin
               req_link.valid <= 1'b0;
            end
         end
      end
   end

   // Response receiver: random stalls plus long hold-offs that back up the input
   always @(posedge clock) begin
      if (reset) begin
         rsp_link.ready <= 1'b0;
         hold_left      <= 0;
         next_hold_at   <= FIRST_HOLD_AT;
      end else if (hold_left != 0) begin
         rsp_link.ready <= 1'b0;
         hold_left      <= hold_left - 1;
      end else if (next_hold_at != 0 && accepted_count >= next_hold_at) begin
         rsp_link.ready <= 1'b0;
         hold_left      <= HOLD_CYCLES;
         next_hold_at   <= (next_hold_at == FIRST_HOLD_AT) ? SECOND_HOLD_AT : 0;
      end else begin
         rsp_link.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
   end

   // Response monitor: compare each transfer with the oldest report due
   always @(posedge clock) begin
      if (!reset && rsp_link.valid && rsp_link.ready) begin
         if (cell_reports_due.size() == 0) begin
            report_mismatch("response with no report due");
         end else begin
            arrived_report = cell_reports_due.pop_front();
            if (rsp_link.cell_alive !== arrived_report.cell_alive) begin
               report_mismatch($sformatf("cell_alive got %b want %b",
                               rsp_link.cell_alive, arrived_report.cell_alive));
            end
            if (rsp_link.neighbour_count !== arrived_report.neighbour_count) begin
               report_mismatch($sformatf("neighbour_count got %0d want %0d",
                               rsp_link.neighbour_count, arrived_report.neighbour_count));
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

endmodule

`default_nettype wire

@@ life_grid_generation_step.f @@
hw/rtl/lgs_pkg.sv
hw/rtl/lgs_req_if.sv
hw/rtl/lgs_rsp_if.sv
hw/rtl/lgs_datapath.sv
hw/rtl/lgs_ctrl.sv
hw/rtl/life_grid_generation_step.sv
sim/tb_life_grid_generation_step.sv
